// ===== hdl/zpdf_pkg.sv =====
// ----------------------------------------------------------------------------
// zpdf_pkg
// shared types and constants of the zero-padded decimal formatter
// ----------------------------------------------------------------------------
`default_nettype none

package zpdf_pkg;

  localparam int unsigned MAG_W      = 32;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned NDIG_W     = 4;
  localparam int unsigned WIDTH_W    = 6;
  localparam int unsigned CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SKIP,
    ST_SIGN,
    ST_PAD,
    ST_DIGIT
  } emit_state_t;

  typedef struct packed {
    logic                neg;
    logic                zero_pad;
    logic [WIDTH_W-1:0]  width;
  } job_t;

endpackage

`default_nettype wire

// ===== hdl/zpdf_dabble.sv =====
// ----------------------------------------------------------------------------
// zpdf_dabble
// bit-serial binary to bcd converter, one magnitude bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module zpdf_dabble (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [zpdf_pkg::MAG_W-1:0]  mag,
  output logic                             done,
  output logic [zpdf_pkg::BCD_W-1:0]       bcd
);

  logic [zpdf_pkg::MAG_W-1:0] mag_r, mag_nxt;
  logic [zpdf_pkg::BCD_W-1:0] bcd_r, bcd_nxt;
  logic [zpdf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       run_r, run_nxt;
  logic                       done_r, done_nxt;
  logic [zpdf_pkg::BCD_W-1:0] adj;

  // add three to every digit of five or more
  always_comb begin
    for (int i = 0; i < zpdf_pkg::BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      mag_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = zpdf_pkg::CNT_W'(zpdf_pkg::MAG_W - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      mag_nxt = {mag_r[zpdf_pkg::MAG_W-2:0], 1'b0};
      bcd_nxt = {adj[zpdf_pkg::BCD_W-2:0], mag_r[zpdf_pkg::MAG_W-1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

`default_nettype wire

// ===== hdl/zpdf_emit.sv =====
// ----------------------------------------------------------------------------
// zpdf_emit
// character sequencer: skips leading zeros, then sends sign, pad and digits
// ----------------------------------------------------------------------------
`default_nettype none

module zpdf_emit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [zpdf_pkg::BCD_W-1:0]    bcd,
  input  wire zpdf_pkg::job_t                job,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic [zpdf_pkg::CHAR_W-1:0]        out_character,
  output logic                               out_last_char
);

  zpdf_pkg::emit_state_t state_r, state_nxt;

  logic [zpdf_pkg::BCD_W-1:0]   dig_r, dig_nxt;
  logic [zpdf_pkg::NDIG_W-1:0]  ndig_r, ndig_nxt;
  logic [zpdf_pkg::WIDTH_W-1:0] zeros_r, zeros_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [zpdf_pkg::CHAR_W-1:0]  out_character_r, out_character_nxt;
  logic                         out_last_char_r, out_last_char_nxt;

  logic                         slot_free;
  logic                         lead_zero;
  logic [zpdf_pkg::WIDTH_W-1:0] len;
  logic [zpdf_pkg::WIDTH_W-1:0] zeros_calc;
  logic [3:0]                   top_digit;

  assign slot_free = !out_valid_r || !out_stall;
  assign top_digit = dig_r[zpdf_pkg::BCD_W-1 -: 4];
  assign lead_zero = (top_digit == 4'd0) && (ndig_r > zpdf_pkg::NDIG_W'(1));
  assign len       = zpdf_pkg::WIDTH_W'(ndig_r) + zpdf_pkg::WIDTH_W'(job.neg);
  assign zeros_calc = (job.zero_pad && (job.width > len)) ? (job.width - len) : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      zpdf_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = zpdf_pkg::ST_SKIP;
        end
      end
      zpdf_pkg::ST_SKIP: begin
        if (!lead_zero) begin
          if (job.neg) begin
            state_nxt = zpdf_pkg::ST_SIGN;
          end else if (zeros_calc != '0) begin
            state_nxt = zpdf_pkg::ST_PAD;
          end else begin
            state_nxt = zpdf_pkg::ST_DIGIT;
          end
        end
      end
      zpdf_pkg::ST_SIGN: begin
        if (slot_free) begin
          if (zeros_r != '0) begin
            state_nxt = zpdf_pkg::ST_PAD;
          end else begin
            state_nxt = zpdf_pkg::ST_DIGIT;
          end
        end
      end
      zpdf_pkg::ST_PAD: begin
        if (slot_free && (zeros_r == zpdf_pkg::WIDTH_W'(1))) begin
          state_nxt = zpdf_pkg::ST_DIGIT;
        end
      end
      zpdf_pkg::ST_DIGIT: begin
        if (slot_free && (ndig_r == zpdf_pkg::NDIG_W'(1))) begin
          state_nxt = zpdf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = zpdf_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and output beat
  always_comb begin
    dig_nxt           = dig_r;
    ndig_nxt          = ndig_r;
    zeros_nxt         = zeros_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_character_nxt = out_character_r;
    out_last_char_nxt = out_last_char_r;
    case (state_r)
      zpdf_pkg::ST_IDLE: begin
        if (start) begin
          dig_nxt  = bcd;
          ndig_nxt = zpdf_pkg::NDIG_W'(zpdf_pkg::BCD_DIGITS);
        end
      end
      zpdf_pkg::ST_SKIP: begin
        if (lead_zero) begin
          dig_nxt  = {dig_r[zpdf_pkg::BCD_W-5:0], 4'd0};
          ndig_nxt = ndig_r - 1'b1;
        end else begin
          zeros_nxt = zeros_calc;
        end
      end
      zpdf_pkg::ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = zpdf_pkg::CHAR_MINUS;
          out_last_char_nxt = 1'b0;
        end
      end
      zpdf_pkg::ST_PAD: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = zpdf_pkg::CHAR_ZERO;
          out_last_char_nxt = 1'b0;
          zeros_nxt         = zeros_r - 1'b1;
        end
      end
      zpdf_pkg::ST_DIGIT: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = zpdf_pkg::CHAR_ZERO + zpdf_pkg::CHAR_W'(top_digit);
          out_last_char_nxt = (ndig_r == zpdf_pkg::NDIG_W'(1));
          dig_nxt           = {dig_r[zpdf_pkg::BCD_W-5:0], 4'd0};
          ndig_nxt          = ndig_r - 1'b1;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zpdf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r           <= dig_nxt;
    ndig_r          <= ndig_nxt;
    zeros_r         <= zeros_nxt;
    out_character_r <= out_character_nxt;
    out_last_char_r <= out_last_char_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last_char = out_last_char_r;

endmodule

`default_nettype wire

// ===== hdl/zero_padded_decimal_formatter.sv =====
// ----------------------------------------------------------------------------
// zero_padded_decimal_formatter
// prints a signed 32-bit integer as decimal ascii, one character per beat
//
// in_value, in_min_width and in_zero_pad form one input beat; each result
// beat carries one character ('-' or '0'..'9') and out_last_char marks the
// final character of the number. with in_zero_pad set, zeros follow the
// sign until the text is in_min_width long (widths above MAX_WIDTH clamp).
// in_stall stays high from acceptance until the last character is taken,
// so the next number is accepted in the cycle after the last beat at the earliest.
// the magnitude goes through a bit-serial double-dabble converter, then
// leading zeros are skipped at one digit per cycle (up to nine), then one
// character leaves per cycle into the output register while out_stall is
// low. out_stall holds the output register and pauses the sequencer.
// reset (synchronous, rst_n low) empties the output and returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_padded_decimal_formatter #(
  parameter int unsigned MAX_WIDTH = 63
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [zpdf_pkg::MAG_W-1:0]  in_value,
  input  wire logic [zpdf_pkg::WIDTH_W-1:0]       in_min_width,
  input  wire logic                               in_zero_pad,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [zpdf_pkg::CHAR_W-1:0]             out_character,
  output logic                                    out_last_char
);

  localparam logic [zpdf_pkg::WIDTH_W-1:0] MaxW = zpdf_pkg::WIDTH_W'(MAX_WIDTH);

  logic                       busy_r, busy_nxt;
  zpdf_pkg::job_t             job_r, job_nxt;
  logic                       in_fire;
  logic                       out_fire;
  logic                       neg;
  logic [zpdf_pkg::MAG_W-1:0] mag;
  logic                       conv_done;
  logic [zpdf_pkg::BCD_W-1:0] conv_bcd;

  assign in_fire  = in_valid && !busy_r;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = busy_r;

  assign neg = in_value[zpdf_pkg::MAG_W-1];
  assign mag = neg ? (zpdf_pkg::MAG_W'(0) - zpdf_pkg::MAG_W'(in_value))
                   : zpdf_pkg::MAG_W'(in_value);

  always_comb begin
    job_nxt  = job_r;
    busy_nxt = busy_r;
    if (in_fire) begin
      job_nxt.neg      = neg;
      job_nxt.zero_pad = in_zero_pad;
      job_nxt.width    = (in_min_width > MaxW) ? MaxW : in_min_width;
      busy_nxt         = 1'b1;
    end else if (out_fire && out_last_char) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  zpdf_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  zpdf_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (conv_done),
    .bcd           (conv_bcd),
    .job           (job_r),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("block not busy after accepting a beat");

  a_out_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r)
    else $error("result beat while no number is in flight");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == zpdf_pkg::CHAR_MINUS ||
                   (out_character >= zpdf_pkg::CHAR_ZERO &&
                    out_character <= zpdf_pkg::CHAR_NINE)))
    else $error("character outside sign and digit codes");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_character == zpdf_pkg::CHAR_MINUS) |-> !out_last_char)
    else $error("sign marked as last character");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks the zero-padded decimal formatter one character beat at a time
//
// every accepted number is turned into its expected character text, either
// typed in for the simple directed rows or worked out by a local predictor
// (sign, zero padding, digits, last-character flag), and each result beat is
// compared with the oldest expected character. a directed table comes first,
// then random numbers weighted towards decimal boundaries and extremes, with
// random idle bursts both sides, none in every third run of 45 or the last 60.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIDTH_CAP    = 63;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT  = 1_200_000;

  typedef struct packed {
    logic [zpdf_pkg::CHAR_W-1:0] character;
    logic                        last_char;
  } text_beat_t;

  typedef struct {
    logic signed [zpdf_pkg::MAG_W-1:0] value;
    logic [zpdf_pkg::WIDTH_W-1:0]      min_width;
    logic                              zero_pad;
    string                             golden;
  } number_row_t;

  logic                              clk           = 1'b0;
  logic                              rst_n         = 1'b0;
  logic                              in_valid      = 1'b0;
  logic signed [zpdf_pkg::MAG_W-1:0] in_value      = '0;
  logic [zpdf_pkg::WIDTH_W-1:0]      in_min_width  = '0;
  logic                              in_zero_pad   = 1'b0;
  logic                              out_stall     = 1'b0;
  logic                              in_stall;
  logic                              out_valid;
  logic [zpdf_pkg::CHAR_W-1:0]       out_character;
  logic                              out_last_char;

  text_beat_t    pending_text[$];
  number_row_t   directed_rows[$];
  text_beat_t    head_beat;
  logic          idle_on       = 1'b1;
  int unsigned   stall_left    = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count   = 0;

  zero_padded_decimal_formatter #(
    .MAX_WIDTH(WIDTH_CAP)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_min_width (in_min_width),
    .in_zero_pad  (in_zero_pad),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last_char(out_last_char)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // expected text of one number: sign, padding zeros, then the digits
  function automatic void predict_text(logic signed [zpdf_pkg::MAG_W-1:0] value,
                                       logic [zpdf_pkg::WIDTH_W-1:0] min_width,
                                       logic zero_pad);
    logic                        neg;
    logic [zpdf_pkg::MAG_W-1:0]  mag;
    logic [3:0]                  digit_q[$];
    logic [zpdf_pkg::CHAR_W-1:0] text_q[$];
    int unsigned                 width;
    int unsigned                 len;
    int unsigned                 zeros;
    neg = value[zpdf_pkg::MAG_W-1];
    mag = value;
    if (neg) mag = -mag;
    width = 32'(min_width);
    if (width > WIDTH_CAP) width = WIDTH_CAP;
    do begin
      digit_q.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    len = digit_q.size() + (neg ? 1 : 0);
    zeros = (zero_pad && width > len) ? width - len : 0;
    if (neg) text_q.push_back(zpdf_pkg::CHAR_MINUS);
    repeat (zeros) text_q.push_back(zpdf_pkg::CHAR_ZERO);
    foreach (digit_q[i])
      text_q.push_back(zpdf_pkg::CHAR_ZERO + zpdf_pkg::CHAR_W'(digit_q[i]));
    foreach (text_q[i]) pending_text.push_back('{text_q[i], i == text_q.size() - 1});
  endfunction

  function automatic void queue_golden(string golden);
    for (int i = 0; i < golden.len(); i++)
      pending_text.push_back('{zpdf_pkg::CHAR_W'(golden[i]), i == golden.len() - 1});
  endfunction

  task automatic drive_number(number_row_t row);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_value     <= row.value;
    in_min_width <= row.min_width;
    in_zero_pad  <= row.zero_pad;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (row.golden.len() != 0) queue_golden(row.golden);
    else predict_text(row.value, row.min_width, row.zero_pad);
  endtask

  function automatic logic signed [zpdf_pkg::MAG_W-1:0] pick_value();
    int unsigned                       pow;
    logic signed [zpdf_pkg::MAG_W-1:0] v;
    pow = 1;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 999);
      3: begin
        repeat ($urandom_range(0, 9)) pow = pow * 10;
        v = pow + $urandom_range(0, 2) - 1;
      end
      4: v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                  : 32'sh8000_0000 + $urandom_range(0, 3);
      default: v = $urandom_range(0, 99999);
    endcase
    if ($urandom_range(0, 1) && v != 32'sh8000_0000) v = -v;
    return v;
  endfunction

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_text.size() == 0) begin
        report_mismatch($sformatf("unexpected beat char %0d last %0b",
                                  out_character, out_last_char));
      end else begin
        head_beat = pending_text.pop_front();
        if (out_character !== head_beat.character)
          report_mismatch($sformatf("character %0d, wanted %0d",
                                    out_character, head_beat.character));
        if (out_last_char !== head_beat.last_char)
          report_mismatch($sformatf("last_char %0b, wanted %0b",
                                    out_last_char, head_beat.last_char));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    number_row_t row;
    directed_rows.push_back('{32'sd0,          6'd0,  1'b0, "0"});
    directed_rows.push_back('{32'sd0,          6'd63, 1'b1, ""});
    directed_rows.push_back('{32'sd0,          6'd63, 1'b0, "0"});
    directed_rows.push_back('{32'sh7FFF_FFFF,  6'd0,  1'b0, "2147483647"});
    directed_rows.push_back('{32'sh7FFF_FFFF,  6'd63, 1'b1, ""});
    directed_rows.push_back('{32'sh8000_0000,  6'd0,  1'b0, "-2147483648"});
    directed_rows.push_back('{32'sh8000_0000,  6'd11, 1'b1, "-2147483648"});
    directed_rows.push_back('{32'sh8000_0000,  6'd63, 1'b1, ""});
    directed_rows.push_back('{-32'sd1,         6'd0,  1'b0, "-1"});
    directed_rows.push_back('{-32'sd1,         6'd5,  1'b1, "-0001"});
    directed_rows.push_back('{32'sd42,         6'd5,  1'b0, "42"});
    directed_rows.push_back('{32'sd42,         6'd2,  1'b1, "42"});
    directed_rows.push_back('{32'sd42,         6'd1,  1'b1, "42"});
    directed_rows.push_back('{32'sd42,         6'd3,  1'b1, "042"});
    directed_rows.push_back('{-32'sd7,         6'd2,  1'b1, "-7"});
    directed_rows.push_back('{-32'sd7,         6'd3,  1'b1, "-07"});
    directed_rows.push_back('{32'sd9,          6'd10, 1'b1, ""});
    directed_rows.push_back('{32'sd10,         6'd0,  1'b1, "10"});
    directed_rows.push_back('{32'sd1000000000, 6'd12, 1'b1, ""});
    directed_rows.push_back('{32'sd999999999,  6'd0,  1'b0, ""});
    directed_rows.push_back('{-32'sd999999999, 6'd20, 1'b1, ""});
    directed_rows.push_back('{32'sd123456789,  6'd42, 1'b1, ""});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) drive_number(directed_rows[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on       = (i < RANDOM_ITEMS - 60) && ((i / 45) % 3 != 2);
      row.value     = pick_value();
      row.min_width = ($urandom_range(0, 7) == 0)
                      ? zpdf_pkg::WIDTH_W'($urandom_range(0, 63))
                      : zpdf_pkg::WIDTH_W'($urandom_range(0, 15));
      row.zero_pad  = 1'($urandom_range(0, 1));
      row.golden    = "";
      drive_number(row);
    end
    in_valid <= 1'b0;

    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/zpdf_pkg.sv
hdl/zpdf_dabble.sv
hdl/zpdf_emit.sv
hdl/zero_padded_decimal_formatter.sv
test/tb_top.sv
